[rtl/core/tcgw_pkg.sv]
// Shared types and constants for the text console grid writer.
`default_nettype none

package tcgw_pkg;

    // Default geometry
    localparam int GRID_ROWS_DEF = 22;
    localparam int GRID_COLS_DEF = 56;
    localparam int TAB_STOP_DEF  = 4;

    // Command field
    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Control bytes
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NUL   = 8'd0;

    // Work classes handed from the front end to the executor
    typedef enum logic [2:0] {
        OP_READ,
        OP_READ_ZERO,
        OP_NOP,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_TAB,
        OP_PRINT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } item_ctl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_READ_WAIT,
        ST_NEWLINE,
        ST_BACKSPACE,
        ST_TAB,
        ST_PRINT,
        ST_PRINT_WR,
        ST_PRINT_CLR,
        ST_BLANK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/core/text_console_grid_writer.sv]
// Top level of the text console grid writer: front end, queue, executor, grid RAM.
// The executor takes one input beat at a time; a scroll blanks the new last row,
// one cell per cycle. A two-entry queue lets the input side run ahead of the executor.
// Reset: async, active low; then a clearing pass over all GRID_ROWS*GRID_COLS cells (1232)
// with in_stall high, cursor at row 0, column 0.
`default_nettype none

module text_console_grid_writer
    import tcgw_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int TAB_STOP  = TAB_STOP_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       cmd,
    input  wire logic [7:0] data_byte,
    input  wire logic [4:0] read_row,
    input  wire logic [5:0] read_col,
    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] cell_value,
    output logic      [4:0] cursor_row,
    output logic      [5:0] cursor_col,
    output logic            scrolled
);

    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int DEPTH  = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    // Front-to-back queue head
    logic             q_valid;
    logic             q_pop;
    item_ctl_t        q_ctl;
    logic [ROW_W-1:0] q_row;
    logic [COL_W-1:0] q_col;
    logic             busy;

    // Grid RAM port. Rows are kept as a circular buffer so a scroll is a
    // base-row bump plus blanking one row instead of moving the whole grid.
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wr_data;
    logic [7:0]        mem_rd_data;

    // Classification and queueing of incoming beats
    tcgw_front #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .data_byte (data_byte),
        .read_row  (read_row),
        .read_col  (read_col),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_ctl     (q_ctl),
        .q_row     (q_row),
        .q_col     (q_col)
    );

    // Cursor, grid sequencing and the result register
    tcgw_back #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .TAB_STOP  (TAB_STOP)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_ctl       (q_ctl),
        .q_row       (q_row),
        .q_col       (q_col),
        .busy        (busy),
        .mem_wr_en   (mem_wr_en),
        .mem_rd_en   (mem_rd_en),
        .mem_addr    (mem_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_value  (cell_value),
        .cursor_row  (cursor_row),
        .cursor_col  (cursor_col),
        .scrolled    (scrolled)
    );

    // Character grid storage
    tcgw_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

[rtl/core/tcgw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcgw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1232
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/tcgw_front.sv]
// Front end: takes input beats, classifies them and queues them for the executor.
`default_nettype none

module tcgw_front
    import tcgw_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF,
    localparam int ROW_W = $clog2(GRID_ROWS),
    localparam int COL_W = $clog2(GRID_COLS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             cmd,
    input  wire logic [7:0]       data_byte,
    input  wire logic [4:0]       read_row,
    input  wire logic [5:0]       read_col,
    input  wire logic             busy,
    output logic                  q_valid,
    input  wire logic             q_pop,
    output item_ctl_t             q_ctl,
    output logic      [ROW_W-1:0] q_row,
    output logic      [COL_W-1:0] q_col
);

    localparam int QDEPTH = 2;
    localparam int QP_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    item_ctl_t        ctl_reg [QDEPTH];
    logic [ROW_W-1:0] row_reg [QDEPTH];
    logic [COL_W-1:0] col_reg [QDEPTH];
    logic [QP_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  count_reg, count_next;

    item_ctl_t new_ctl;
    logic      in_range;
    logic      push;

    // Classify the beat
    always_comb
    begin
        in_range = (32'(read_row) < GRID_ROWS) && (32'(read_col) < GRID_COLS);
        new_ctl.data_byte = data_byte;
        if (cmd == CMD_READ)
        begin
            new_ctl.op = in_range ? OP_READ : OP_READ_ZERO;
        end
        else
        begin
            unique case (data_byte) inside
                CH_CR:          new_ctl.op = OP_NOP;
                CH_LF:          new_ctl.op = OP_NEWLINE;
                CH_BS, CH_DEL:  new_ctl.op = OP_BACKSPACE;
                CH_TAB:         new_ctl.op = OP_TAB;
                default:        new_ctl.op = OP_PRINT;
            endcase
        end
    end

    assign in_stall = (count_reg == QC_W'(QDEPTH)) || busy;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_ctl    = ctl_reg[rd_ptr_reg];
    assign q_row    = row_reg[rd_ptr_reg];
    assign q_col    = col_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_reg[wr_ptr_reg] <= new_ctl;
            row_reg[wr_ptr_reg] <= ROW_W'(read_row);
            col_reg[wr_ptr_reg] <= COL_W'(read_col);
        end
    end

endmodule

`default_nettype wire

[rtl/core/tcgw_back.sv]
// Executor: cursor, grid sequencing through the RAM, result register.
`default_nettype none

module tcgw_back
    import tcgw_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int TAB_STOP  = TAB_STOP_DEF,
    localparam int ROW_W  = $clog2(GRID_ROWS),
    localparam int COL_W  = $clog2(GRID_COLS),
    localparam int DEPTH  = GRID_ROWS * GRID_COLS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire item_ctl_t         q_ctl,
    input  wire logic [ROW_W-1:0]  q_row,
    input  wire logic [COL_W-1:0]  q_col,
    output logic                   busy,
    output logic                   mem_wr_en,
    output logic                   mem_rd_en,
    output logic      [ADDR_W-1:0] mem_addr,
    output logic      [7:0]        mem_wr_data,
    input  wire logic [7:0]        mem_rd_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [7:0]        cell_value,
    output logic      [4:0]        cursor_row,
    output logic      [5:0]        cursor_col,
    output logic                   scrolled
);

    localparam int PH_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [7:0]       byte_reg, byte_next;
    logic [ROW_W-1:0] rrow_reg, rrow_next;
    logic [COL_W-1:0] rcol_reg, rcol_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] phys_reg, phys_next;
    logic [ROW_W-1:0] base_reg, base_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [7:0]       res_cell_reg, res_cell_next;
    logic             res_scroll_reg, res_scroll_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_cell_reg, out_cell_next;
    logic [4:0]       out_row_reg, out_row_next;
    logic [5:0]       out_col_reg, out_col_next;
    logic             out_scroll_reg, out_scroll_next;

    logic [ROW_W-1:0] sel_row;
    logic [COL_W-1:0] sel_col;
    logic [ROW_W:0]   rd_sum;
    logic [ROW_W-1:0] rd_phys;
    logic [ROW_W-1:0] phys_inc, base_inc;
    logic [PH_W-1:0]  phase_inc, phase_dec;
    logic [COL_W-1:0] col_p1;
    logic             last_row, at_edge;

    // Logical row to physical row of the circular row buffer
    always_comb
    begin
        rd_sum   = {1'b0, base_reg} + {1'b0, rrow_reg};
        rd_phys  = (32'(rd_sum) >= GRID_ROWS) ? ROW_W'(32'(rd_sum) - GRID_ROWS)
                                              : ROW_W'(rd_sum);
        phys_inc = (phys_reg == ROW_W'(GRID_ROWS - 1)) ? '0 : phys_reg + 1'b1;
        base_inc = (base_reg == ROW_W'(GRID_ROWS - 1)) ? '0 : base_reg + 1'b1;
        phase_inc = (phase_reg == PH_W'(TAB_STOP - 1)) ? '0 : phase_reg + 1'b1;
        phase_dec = (phase_reg == '0) ? PH_W'(TAB_STOP - 1) : phase_reg - 1'b1;
        col_p1   = col_reg + 1'b1;
        last_row = (row_reg == ROW_W'(GRID_ROWS - 1));
        at_edge  = (col_reg >= COL_W'(GRID_COLS - 1));
    end

    // Clearing pass walks the flat address; otherwise row/column addressing
    assign mem_addr = (state_reg == ST_CLEAR) ? cnt_reg
                    : ADDR_W'(sel_row) * ADDR_W'(GRID_COLS) + ADDR_W'(sel_col);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        byte_next       = byte_reg;
        rrow_next       = rrow_reg;
        rcol_next       = rcol_reg;
        row_next        = row_reg;
        phys_next       = phys_reg;
        base_next       = base_reg;
        col_next        = col_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        res_cell_next   = res_cell_reg;
        res_scroll_next = res_scroll_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_cell_next   = out_cell_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_scroll_next = out_scroll_reg;
        q_pop           = 1'b0;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_wr_data     = CH_NUL;
        sel_row         = phys_reg;
        sel_col         = col_reg;

        unique case (state_reg) inside
            ST_CLEAR:
            begin
                // Post-reset sweep, one cell per cycle
                mem_wr_en = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    op_next         = q_ctl.op;
                    byte_next       = q_ctl.data_byte;
                    rrow_next       = q_row;
                    rcol_next       = q_col;
                    res_cell_next   = CH_NUL;
                    res_scroll_next = 1'b0;
                    pend_next       = 1'b0;
                    unique case (q_ctl.op)
                        OP_READ:      state_next = ST_READ;
                        OP_NEWLINE:   state_next = ST_NEWLINE;
                        OP_BACKSPACE: state_next = ST_BACKSPACE;
                        OP_TAB:       state_next = ST_TAB;
                        OP_PRINT:     state_next = ST_PRINT;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ:
            begin
                mem_rd_en  = 1'b1;
                sel_row    = rd_phys;
                sel_col    = rcol_reg;
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                res_cell_next = mem_rd_data;
                state_next    = ST_DONE;
            end
            ST_NEWLINE, ST_PRINT:
            begin
                if (state_reg == ST_PRINT && !at_edge)
                begin
                    state_next = ST_PRINT_WR;
                end
                else
                begin
                    col_next   = '0;
                    phase_next = '0;
                    if (!last_row)
                    begin
                        row_next   = row_reg + 1'b1;
                        phys_next  = phys_inc;
                        state_next = (state_reg == ST_PRINT) ? ST_PRINT_WR : ST_DONE;
                    end
                    else
                    begin
                        // Scroll: oldest physical row becomes the blank last row
                        base_next       = base_inc;
                        phys_next       = base_reg;
                        res_scroll_next = 1'b1;
                        cnt_next        = '0;
                        pend_next       = (state_reg == ST_PRINT);
                        state_next      = ST_BLANK;
                    end
                end
            end
            ST_BLANK:
            begin
                mem_wr_en = 1'b1;
                sel_col   = cnt_reg[COL_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(GRID_COLS - 1))
                begin
                    state_next = pend_reg ? ST_PRINT_WR : ST_DONE;
                end
            end
            ST_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    mem_wr_en  = 1'b1;
                    sel_col    = col_reg - 1'b1;
                    col_next   = col_reg - 1'b1;
                    phase_next = phase_dec;
                end
                state_next = ST_DONE;
            end
            ST_TAB:
            begin
                if (!at_edge)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = CH_SPACE;
                    col_next    = col_p1;
                    phase_next  = phase_inc;
                    if (phase_inc == '0 || col_p1 >= COL_W'(GRID_COLS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PRINT_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = byte_reg;
                col_next    = col_p1;
                phase_next  = phase_inc;
                state_next  = ST_PRINT_CLR;
            end
            ST_PRINT_CLR:
            begin
                mem_wr_en  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_cell_next   = res_cell_reg;
                    out_row_next    = 5'(row_reg);
                    out_col_next    = 6'(col_reg);
                    out_scroll_next = res_scroll_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            phys_reg      <= '0;
            base_reg      <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            phys_reg      <= phys_next;
            base_reg      <= base_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        byte_reg       <= byte_next;
        rrow_reg       <= rrow_next;
        rcol_reg       <= rcol_next;
        res_cell_reg   <= res_cell_next;
        res_scroll_reg <= res_scroll_next;
        out_cell_reg   <= out_cell_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_scroll_reg <= out_scroll_next;
    end

    assign busy       = (state_reg == ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign cell_value = out_cell_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign scrolled   = out_scroll_reg;

endmodule

`default_nettype wire

[rtl/core/tcgw_checker.sv]
// Port-level checker for the text console grid writer, bound to the top level.
`default_nettype none

module tcgw_checker
    import tcgw_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] cell_value,
    input wire logic [4:0] cursor_row,
    input wire logic [5:0] cursor_col,
    input wire logic       scrolled
);

    // Result beat holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_value) &&
        $stable(cursor_row) && $stable(cursor_col) && $stable(scrolled))
        else $error("result beat changed under stall");

    // A scroll leaves the cursor on the last row at column 0 or 1
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |->
        cursor_row == 5'(GRID_ROWS - 1) && cursor_col <= 6'd1)
        else $error("scroll reported off the last row");

    // Cursor always inside the grid
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(cursor_row) < GRID_ROWS && 32'(cursor_col) < GRID_COLS)
        else $error("cursor outside grid");

    // Clearing pass blocks input right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall && !out_valid)
        else $error("input taken during clearing pass");

    // No result shows right after reset is released
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !out_valid)
        else $error("result without input");

endmodule

bind text_console_grid_writer tcgw_checker #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
) u_tcgw_checker (.*);

`default_nettype wire
